// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros shared by the chunk deframer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/pcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcd_pkg
// types and constants shared by the png chunk deframer modules
// ----------------------------------------------------------------------------
package pcd_pkg;

    // result kinds
    localparam logic [1:0] C_KIND_DATA    = 2'd0;
    localparam logic [1:0] C_KIND_DONE    = 2'd1;
    localparam logic [1:0] C_KIND_BAD_SIG = 2'd2;
    localparam logic [1:0] C_KIND_TRUNC   = 2'd3;

    // file signature
    localparam int unsigned C_SIG_LENGTH = 8;
    localparam logic [7:0] C_SIG_BYTES [C_SIG_LENGTH] = '{
        8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10
    };

    // chunk types of interest
    localparam logic [31:0] C_TYPE_IHDR = 32'h4948_4452;
    localparam logic [31:0] C_TYPE_IDAT = 32'h4944_4154;

    // saturated payload length
    localparam logic [30:0] C_MAX_LENGTH = 31'h7FFF_FFFF;

    // result queue sizing
    localparam int unsigned C_QUEUE_DEPTH = 4;
    localparam int unsigned C_QPTR_BITS   = 2;

    // one result record
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  payload_byte;
        logic        chunk_payload_last;
        logic [31:0] chunk_type;
        logic [30:0] chunk_length;
        logic [31:0] stored_crc;
        logic [31:0] chunk_offset;
        logic [31:0] image_width;
        logic [31:0] image_height;
    } t_record;

    // front to queue write side
    typedef struct packed {
        logic    push;
        t_record record;
    } t_push;

endpackage

// ===== hw/rtl/pcd_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pcd_front
// byte parser: checks the signature, walks the chunk fields and builds one
// result record per byte that produces one
// ----------------------------------------------------------------------------
module pcd_front #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last_byte,
    output pcd_pkg::t_push      o_push,
    input  logic                i_full
);

    // parser phases
    localparam logic [2:0] PH_SIG     = 3'd0;
    localparam logic [2:0] PH_LEN     = 3'd1;
    localparam logic [2:0] PH_TYPE    = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CRC     = 3'd4;
    localparam logic [2:0] PH_SKIP    = 3'd5;

    logic [2:0]               r_phase,          n_phase;
    logic [2:0]               r_field_index,    n_field_index;
    logic [30:0]              r_payload_count,  n_payload_count;
    logic [31:0]              r_length_word,    n_length_word;
    logic [31:0]              r_type_word,      n_type_word;
    logic [31:0]              r_crc_word,       n_crc_word;
    logic [POSITION_BITS-1:0] r_file_position,  n_file_position;
    logic [POSITION_BITS-1:0] r_chunk_start,    n_chunk_start;
    logic [31:0]              r_width_word,     n_width_word;
    logic [31:0]              r_height_word,    n_height_word;

    logic                     w_accept;
    logic [30:0]              w_len_eff;
    logic [30:0]              w_len_next;
    logic [30:0]              w_count_inc;
    logic [POSITION_BITS+31:0] w_start_ext;
    logic                     w_has;
    logic                     w_trunc;
    logic [1:0]               w_kind;
    logic [7:0]               w_pbyte;
    logic                     w_plast;
    logic [31:0]              w_crc;

    assign w_accept    = i_valid && !i_full;
    assign o_stall     = i_full;
    assign w_len_eff   = r_length_word[31] ? pcd_pkg::C_MAX_LENGTH : r_length_word[30:0];
    assign w_count_inc = r_payload_count + 31'd1;

    // next state and result for the byte on the input
    always_comb begin
        n_phase         = r_phase;
        n_field_index   = r_field_index;
        n_payload_count = r_payload_count;
        n_length_word   = r_length_word;
        n_type_word     = r_type_word;
        n_crc_word      = r_crc_word;
        n_file_position = r_file_position + {{(POSITION_BITS-1){1'b0}}, 1'b1};
        n_chunk_start   = r_chunk_start;
        n_width_word    = r_width_word;
        n_height_word   = r_height_word;
        w_has           = 1'b0;
        w_trunc         = i_last_byte;
        w_kind          = pcd_pkg::C_KIND_DATA;
        w_pbyte         = 8'd0;
        w_plast         = 1'b0;
        w_crc           = 32'd0;

        unique case (r_phase)
            PH_SIG: begin
                if (i_data_byte != pcd_pkg::C_SIG_BYTES[r_field_index]) begin
                    w_has   = 1'b1;
                    w_kind  = pcd_pkg::C_KIND_BAD_SIG;
                    n_phase = PH_SKIP;
                    w_trunc = 1'b0;
                end else begin
                    n_field_index = r_field_index + 3'd1;
                    if (r_field_index == 3'd7) begin
                        n_phase       = PH_LEN;
                        n_field_index = 3'd0;
                        w_trunc       = 1'b0;
                    end
                end
            end
            PH_LEN: begin
                if (r_field_index == 3'd0) begin
                    n_chunk_start = r_file_position;
                    n_length_word = {24'd0, i_data_byte};
                end else begin
                    n_length_word = {r_length_word[23:0], i_data_byte};
                end
                n_field_index = r_field_index + 3'd1;
                if (r_field_index == 3'd3) begin
                    n_phase       = PH_TYPE;
                    n_field_index = 3'd0;
                end
            end
            PH_TYPE: begin
                if (r_field_index == 3'd0) begin
                    n_type_word = {24'd0, i_data_byte};
                end else begin
                    n_type_word = {r_type_word[23:0], i_data_byte};
                end
                n_field_index = r_field_index + 3'd1;
                if (r_field_index == 3'd3) begin
                    n_field_index   = 3'd0;
                    n_payload_count = 31'd0;
                    if (n_type_word == pcd_pkg::C_TYPE_IHDR) begin
                        n_width_word  = 32'd0;
                        n_height_word = 32'd0;
                    end
                    n_phase = (w_len_eff != 31'd0) ? PH_PAYLOAD : PH_CRC;
                end
            end
            PH_PAYLOAD: begin
                // header chunk: width then height, big-endian
                if (r_type_word == pcd_pkg::C_TYPE_IHDR) begin
                    if (r_payload_count < 31'd4) begin
                        n_width_word = {r_width_word[23:0], i_data_byte};
                    end else if (r_payload_count < 31'd8) begin
                        n_height_word = {r_height_word[23:0], i_data_byte};
                    end
                end
                if (r_type_word == pcd_pkg::C_TYPE_IDAT) begin
                    w_has   = 1'b1;
                    w_kind  = pcd_pkg::C_KIND_DATA;
                    w_pbyte = i_data_byte;
                    w_plast = (w_count_inc == w_len_eff);
                end
                n_payload_count = w_count_inc;
                if (w_count_inc >= w_len_eff) begin
                    n_phase       = PH_CRC;
                    n_field_index = 3'd0;
                end
            end
            PH_CRC: begin
                if (r_field_index == 3'd0) begin
                    n_crc_word = {24'd0, i_data_byte};
                end else begin
                    n_crc_word = {r_crc_word[23:0], i_data_byte};
                end
                n_field_index = r_field_index + 3'd1;
                if (r_field_index == 3'd3) begin
                    w_has         = 1'b1;
                    w_kind        = pcd_pkg::C_KIND_DONE;
                    w_crc         = n_crc_word;
                    n_phase       = PH_LEN;
                    n_field_index = 3'd0;
                    w_trunc       = 1'b0;
                end
            end
            default: begin
                n_phase = PH_SKIP;
                w_trunc = 1'b0;
            end
        endcase

        // file ended inside a field: error replaces any other result
        if (w_trunc) begin
            w_has   = 1'b1;
            w_kind  = pcd_pkg::C_KIND_TRUNC;
            w_pbyte = 8'd0;
            w_plast = 1'b0;
            w_crc   = 32'd0;
        end
    end

    // record fields come from the updated state
    assign w_len_next  = n_length_word[31] ? pcd_pkg::C_MAX_LENGTH : n_length_word[30:0];
    assign w_start_ext = {32'd0, n_chunk_start};

    always_comb begin
        o_push.push                      = w_accept && w_has;
        o_push.record.kind               = w_kind;
        o_push.record.payload_byte       = w_pbyte;
        o_push.record.chunk_payload_last = w_plast;
        o_push.record.chunk_type         = n_type_word;
        o_push.record.chunk_length       = w_len_next;
        o_push.record.stored_crc         = w_crc;
        o_push.record.chunk_offset       = w_start_ext[31:0];
        o_push.record.image_width        = n_width_word;
        o_push.record.image_height       = n_height_word;
    end

    // state registers, rearmed after the last byte of a file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_accept && i_last_byte)) begin
            r_phase         <= PH_SIG;
            r_field_index   <= 3'd0;
            r_payload_count <= 31'd0;
            r_length_word   <= 32'd0;
            r_type_word     <= 32'd0;
            r_crc_word      <= 32'd0;
            r_file_position <= '0;
            r_chunk_start   <= '0;
            r_width_word    <= 32'd0;
            r_height_word   <= 32'd0;
        end else if (w_accept) begin
            r_phase         <= n_phase;
            r_field_index   <= n_field_index;
            r_payload_count <= n_payload_count;
            r_length_word   <= n_length_word;
            r_type_word     <= n_type_word;
            r_crc_word      <= n_crc_word;
            r_file_position <= n_file_position;
            r_chunk_start   <= n_chunk_start;
            r_width_word    <= n_width_word;
            r_height_word   <= n_height_word;
        end
    end

    // checks
    `ASSERT_PROP(a_rearm_after_last, i_clk, i_rst_n, (w_accept && i_last_byte) |=> (r_phase == PH_SIG && r_field_index == 3'd0 && r_file_position == '0))
    `ASSERT_PROP(a_payload_in_range, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_payload_count < w_len_eff))
    `ASSERT_PROP(a_word_index_range, i_clk, i_rst_n, (r_phase == PH_LEN || r_phase == PH_TYPE || r_phase == PH_CRC) |-> (r_field_index < 3'd4))

endmodule

// ===== hw/rtl/pcd_queue.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// pcd_queue
// short result queue between the parser and the output channel; the head
// entry drives the output ports
// ----------------------------------------------------------------------------
module pcd_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pcd_pkg::t_push     i_push,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output pcd_pkg::t_record   o_record
);

    localparam logic [pcd_pkg::C_QPTR_BITS:0] DEPTH = (pcd_pkg::C_QPTR_BITS + 1)'(pcd_pkg::C_QUEUE_DEPTH);

    pcd_pkg::t_record                 r_mem [pcd_pkg::C_QUEUE_DEPTH];
    logic [pcd_pkg::C_QPTR_BITS-1:0]  r_wr_ptr;
    logic [pcd_pkg::C_QPTR_BITS-1:0]  r_rd_ptr;
    logic [pcd_pkg::C_QPTR_BITS:0]    r_count;
    logic                             w_pop;

    assign o_full   = (r_count == DEPTH);
    assign o_valid  = (r_count != '0);
    assign w_pop    = o_valid && !i_stall;
    assign o_record = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.record;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // checks
    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push.push && r_count == DEPTH)
    `ASSERT_PROP(a_pop_drains, i_clk, i_rst_n, (w_pop && !i_push.push) |=> (r_count == $past(r_count) - 1'b1))

endmodule

// ===== hw/rtl/png_chunk_deframer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// png_chunk_deframer_top
// byte-serial png chunk walker: signature check, chunk records, image data
// bytes and header dimensions
// ----------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  input    | in        | i_valid / o_stall | i_data_byte, i_last_byte
//  output   | out       | o_valid / i_stall | o_kind .. o_image_height
//
//  one byte is taken per cycle while o_stall is low; the parser updates its
//  fields in that cycle and writes any result into a four-entry queue, so
//  o_valid rises in the cycle after the byte is taken. o_stall rises only when
//  the queue is full, so input and output stall independently. reset is
//  synchronous and active low; a byte marked last rearms the parser for the next file.
// ----------------------------------------------------------------------------
module png_chunk_deframer_top #(
    parameter int unsigned POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_payload_byte,
    output logic        o_chunk_payload_last,
    output logic [31:0] o_chunk_type,
    output logic [30:0] o_chunk_length,
    output logic [31:0] o_stored_crc,
    output logic [31:0] o_chunk_offset,
    output logic [31:0] o_image_width,
    output logic [31:0] o_image_height
);

    pcd_pkg::t_push   w_push;
    pcd_pkg::t_record w_record;
    logic             w_full;

    // parser
    pcd_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (w_push),
        .i_full      (w_full)
    );

    // result queue
    pcd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_record (w_record)
    );

    // output fields
    assign o_kind               = w_record.kind;
    assign o_payload_byte       = w_record.payload_byte;
    assign o_chunk_payload_last = w_record.chunk_payload_last;
    assign o_chunk_type         = w_record.chunk_type;
    assign o_chunk_length       = w_record.chunk_length;
    assign o_stored_crc         = w_record.stored_crc;
    assign o_chunk_offset       = w_record.chunk_offset;
    assign o_image_width        = w_record.image_width;
    assign o_image_height       = w_record.image_height;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for png_chunk_deframer_top: short directed files, then
// random files built chunk by chunk (header, image data, empty and unknown
// chunks, corrupt signatures, cut-off files, line noise). a scoreboard walks
// every accepted byte through its own chunk parser and compares each output
// transfer field by field with the oldest record it predicted. both sides
// idle at random, with stretches of back-to-back transfers.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_BYTES = 1850;
    localparam int unsigned CYCLE_LIMIT  = 400_000;
    localparam int unsigned DRAIN_CYCLES = 16;

    // scoreboard: parses the byte stream and queues the records it predicts
    class t_chunk_scoreboard;
        typedef enum logic [2:0] {
            ST_SIG, ST_LEN, ST_TYPE, ST_PAYLOAD, ST_CRC, ST_SKIP
        } t_walk_state;

        t_walk_state       state;
        int unsigned       field_idx;
        int unsigned       payload_count;
        logic [31:0]       length_word;
        logic [31:0]       type_word;
        logic [31:0]       crc_word;
        logic [31:0]       file_pos;
        logic [31:0]       chunk_start;
        logic [31:0]       width_word;
        logic [31:0]       height_word;
        pcd_pkg::t_record  expected_records[$];
        int unsigned       mismatches;

        function new();
            rearm();
            mismatches = 0;
        endfunction

        // back to the state after reset, ready for a new file
        function void rearm();
            state         = ST_SIG;
            field_idx     = 0;
            payload_count = 0;
            length_word   = '0;
            type_word     = '0;
            crc_word      = '0;
            file_pos      = '0;
            chunk_start   = '0;
            width_word    = '0;
            height_word   = '0;
        endfunction

        // header length, saturated to 31 bits
        function logic [30:0] payload_length();
            return (length_word > {1'b0, pcd_pkg::C_MAX_LENGTH}) ? pcd_pkg::C_MAX_LENGTH
                                                                 : length_word[30:0];
        endfunction

        function pcd_pkg::t_record make_record(logic [1:0] kind, logic [7:0] data,
                                               logic data_last, logic [31:0] crc);
            pcd_pkg::t_record rec;
            rec.kind               = kind;
            rec.payload_byte       = data;
            rec.chunk_payload_last = data_last;
            rec.chunk_type         = type_word;
            rec.chunk_length       = payload_length();
            rec.stored_crc         = crc;
            rec.chunk_offset       = chunk_start;
            rec.image_width        = width_word;
            rec.image_height       = height_word;
            return rec;
        endfunction

        // one accepted input transfer
        function void walk_byte(logic [7:0] data, logic last);
            pcd_pkg::t_record rec;
            bit               emit;
            bit               cut_short;
            logic [31:0]      pos;
            pos       = file_pos;
            file_pos  = file_pos + 32'd1;
            emit      = 1'b0;
            cut_short = last;
            case (state)
                ST_SIG: begin
                    if (data != pcd_pkg::C_SIG_BYTES[field_idx]) begin
                        rec       = make_record(pcd_pkg::C_KIND_BAD_SIG, 8'd0, 1'b0, 32'd0);
                        emit      = 1'b1;
                        state     = ST_SKIP;
                        cut_short = 1'b0;
                    end else begin
                        field_idx++;
                        if (field_idx >= pcd_pkg::C_SIG_LENGTH) begin
                            state     = ST_LEN;
                            field_idx = 0;
                            cut_short = 1'b0;
                        end
                    end
                end
                ST_LEN: begin
                    if (field_idx == 0) begin
                        chunk_start = pos;
                        length_word = {24'd0, data};
                    end else begin
                        length_word = {length_word[23:0], data};
                    end
                    field_idx++;
                    if (field_idx >= 4) begin
                        state     = ST_TYPE;
                        field_idx = 0;
                    end
                end
                ST_TYPE: begin
                    type_word = (field_idx == 0) ? {24'd0, data} : {type_word[23:0], data};
                    field_idx++;
                    if (field_idx >= 4) begin
                        field_idx     = 0;
                        payload_count = 0;
                        // a header chunk clears the dimensions before capturing
                        if (type_word == pcd_pkg::C_TYPE_IHDR) begin
                            width_word  = '0;
                            height_word = '0;
                        end
                        state = (payload_length() != 0) ? ST_PAYLOAD : ST_CRC;
                    end
                end
                ST_PAYLOAD: begin
                    if (type_word == pcd_pkg::C_TYPE_IHDR) begin
                        if (payload_count < 4)
                            width_word = {width_word[23:0], data};
                        else if (payload_count < 8)
                            height_word = {height_word[23:0], data};
                    end
                    if (type_word == pcd_pkg::C_TYPE_IDAT) begin
                        rec  = make_record(pcd_pkg::C_KIND_DATA, data,
                                           payload_count + 1 == payload_length(), 32'd0);
                        emit = 1'b1;
                    end
                    payload_count++;
                    if (payload_count >= payload_length()) begin
                        state     = ST_CRC;
                        field_idx = 0;
                    end
                end
                ST_CRC: begin
                    crc_word = (field_idx == 0) ? {24'd0, data} : {crc_word[23:0], data};
                    field_idx++;
                    if (field_idx >= 4) begin
                        rec       = make_record(pcd_pkg::C_KIND_DONE, 8'd0, 1'b0, crc_word);
                        emit      = 1'b1;
                        state     = ST_LEN;
                        field_idx = 0;
                        cut_short = 1'b0;
                    end
                end
                default: begin
                    state     = ST_SKIP;
                    cut_short = 1'b0;
                end
            endcase
            // a file ending mid-field overrides whatever this byte produced
            if (cut_short) begin
                rec  = make_record(pcd_pkg::C_KIND_TRUNC, 8'd0, 1'b0, 32'd0);
                emit = 1'b1;
            end
            if (emit)
                expected_records = {expected_records, rec};
            if (last)
                rearm();
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        // one accepted output transfer against the oldest prediction
        function void check_record(pcd_pkg::t_record got);
            pcd_pkg::t_record want;
            if (expected_records.size() == 0) begin
                $error("record with no prediction waiting: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = expected_records.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("chunk_payload_last", want.chunk_payload_last,
                          got.chunk_payload_last);
            compare_field("chunk_type", want.chunk_type, got.chunk_type);
            compare_field("chunk_length", want.chunk_length, got.chunk_length);
            compare_field("stored_crc", want.stored_crc, got.stored_crc);
            compare_field("chunk_offset", want.chunk_offset, got.chunk_offset);
            compare_field("image_width", want.image_width, got.image_width);
            compare_field("image_height", want.image_height, got.image_height);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_payload_byte;
    logic        o_chunk_payload_last;
    logic [31:0] o_chunk_type;
    logic [30:0] o_chunk_length;
    logic [31:0] o_stored_crc;
    logic [31:0] o_chunk_offset;
    logic [31:0] o_image_width;
    logic [31:0] o_image_height;

    t_chunk_scoreboard sb;
    logic [7:0]        file_q[$];
    int unsigned       bytes_sent = 0;
    int unsigned       cycle_count = 0;
    bit                in_calm = 1'b0;
    bit                out_calm = 1'b0;

    png_chunk_deframer_top u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_data_byte          (i_data_byte),
        .i_last_byte          (i_last_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_kind               (o_kind),
        .o_payload_byte       (o_payload_byte),
        .o_chunk_payload_last (o_chunk_payload_last),
        .o_chunk_type         (o_chunk_type),
        .o_chunk_length       (o_chunk_length),
        .o_stored_crc         (o_stored_crc),
        .o_chunk_offset       (o_chunk_offset),
        .o_image_width        (o_image_width),
        .o_image_height       (o_image_height)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // big-endian word into the file under construction
    function automatic void push_word(logic [31:0] w);
        for (int k = 3; k >= 0; k--)
            file_q = {file_q, w[8*k +: 8]};
    endfunction

    // one input transfer, after a random number of idle cycles
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= data;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        sb.walk_byte(data, last);
        bytes_sent++;
    endtask

    // whole file, last flag on its final byte
    task automatic send_file();
        in_calm = ($urandom_range(0, 4) == 0);
        for (int k = 0; k < file_q.size(); k++)
            send_byte(file_q[k], k == file_q.size() - 1);
    endtask

    // random file: mostly well-formed chunk sequences, some broken, some noise
    task automatic build_random_file();
        int          pick;
        int          chunks;
        int          keep;
        bit          huge;
        logic [31:0] chunk_kind;
        logic [31:0] len_word;
        file_q.delete();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            repeat ($urandom_range(1, 20))
                file_q = {file_q, 8'($urandom)};
            return;
        end
        for (int k = 0; k < pcd_pkg::C_SIG_LENGTH; k++)
            file_q = {file_q, pcd_pkg::C_SIG_BYTES[k]};
        if (pick < 13)
            file_q[$urandom_range(0, pcd_pkg::C_SIG_LENGTH - 1)] ^= 8'($urandom_range(1, 255));
        chunks = $urandom_range(0, 5);
        huge   = 1'b0;
        for (int c = 0; c < chunks && !huge; c++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                chunk_kind = pcd_pkg::C_TYPE_IDAT;
                len_word   = $urandom_range(0, 12);
            end else if (pick < 5) begin
                // header chunk, sometimes too short to hold both dimensions
                chunk_kind = pcd_pkg::C_TYPE_IHDR;
                len_word   = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 13;
            end else if (pick == 5) begin
                chunk_kind = 32'h4945_4E44;
                len_word   = 0;
            end else if (pick < 9) begin
                chunk_kind = $urandom;
                len_word   = $urandom_range(0, 6);
            end else begin
                // length far beyond the file, often above the saturation point
                chunk_kind = $urandom_range(0, 1) ? pcd_pkg::C_TYPE_IDAT : $urandom;
                len_word   = $urandom | 32'h0000_1000;
                if ($urandom_range(0, 1))
                    len_word[31] = 1'b1;
                huge = 1'b1;
            end
            push_word(len_word);
            push_word(chunk_kind);
            if (huge) begin
                repeat ($urandom_range(0, 6))
                    file_q = {file_q, 8'($urandom)};
            end else begin
                repeat (len_word)
                    file_q = {file_q, 8'($urandom)};
                push_word($urandom);
            end
        end
        // cut the file off at a random point
        if ($urandom_range(0, 3) == 0) begin
            keep   = $urandom_range(1, file_q.size());
            file_q = file_q[0:keep-1];
        end
    endtask

    // output side: random stall before each transfer, checked at the edge
    task automatic drain_records();
        int gap;
        forever begin
            gap = out_calm ? 0 : $urandom_range(0, 8);
            if ($urandom_range(0, 39) == 0)
                out_calm = !out_calm;
            repeat (gap) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            sb.check_record({o_kind, o_payload_byte, o_chunk_payload_last, o_chunk_type,
                             o_chunk_length, o_stored_crc, o_chunk_offset, o_image_width,
                             o_image_height});
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'd0;
        i_last_byte = 1'b0;
        i_stall     = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_records();
        join_none

        // wrong first byte, file ends on it
        file_q.delete();
        file_q = {file_q, 8'h00};
        send_file();
        // mismatch on the second signature byte, rest ignored up to the end
        file_q.delete();
        file_q = {file_q, pcd_pkg::C_SIG_BYTES[0]};
        file_q = {file_q, 8'hFF};
        file_q = {file_q, 8'h00};
        send_file();
        // file ends inside a matching signature
        file_q.delete();
        for (int k = 0; k < 3; k++)
            file_q = {file_q, pcd_pkg::C_SIG_BYTES[k]};
        send_file();
        // empty image data chunk with an all-ones crc, file ends right after it
        file_q.delete();
        for (int k = 0; k < pcd_pkg::C_SIG_LENGTH; k++)
            file_q = {file_q, pcd_pkg::C_SIG_BYTES[k]};
        push_word(32'd0);
        push_word(pcd_pkg::C_TYPE_IDAT);
        push_word(32'hFFFF_FFFF);
        send_file();

        // random files
        while (bytes_sent < RANDOM_BYTES) begin
            build_random_file();
            send_file();
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        // wait for outstanding records, then a few quiet cycles
        while (sb.expected_records.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
